>>> hdl/bldc_six_step_duty_ramp_unit_defines.svh
// ----------------------------------------------------------------------------
// BLDC six-step duty ramp unit - assertion macros
// Shared property wrappers for the checker of the duty ramp unit.
// ----------------------------------------------------------------------------
`ifndef BLDC_SIX_STEP_DUTY_RAMP_UNIT_DEFINES_SVH
`define BLDC_SIX_STEP_DUTY_RAMP_UNIT_DEFINES_SVH

// same-cycle implication
`define BSDR_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BSDR_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/bsdr_pkg.sv
// ----------------------------------------------------------------------------
// BLDC six-step duty ramp package
// Widths, codes, register indexes and reset values shared by the unit and
// its checker.
// ----------------------------------------------------------------------------
package bsdr_pkg;

   // field widths
   localparam int DIR_W      = 2;
   localparam int SPD_W      = 16;
   localparam int CUR_W      = 12;
   localparam int HALL_W     = 3;
   localparam int CMP_W      = 16;
   localparam int LVL_W      = 15;
   localparam int STEP_W     = 16;
   localparam int DUTY_W     = 19;
   localparam int CTR_W      = 15;
   localparam int FRAC_W     = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 19;

   // signed working widths: duty math and phase drive math
   localparam int ACC_W = DUTY_W + 2;
   localparam int DRV_W = CMP_W + 1;

   // direction codes
   localparam logic [DIR_W-1:0] DIR_STOP     = 2'd0;
   localparam logic [DIR_W-1:0] DIR_LEFT     = 2'd1;
   localparam logic [DIR_W-1:0] DIR_RIGHT    = 2'd2;
   localparam logic [DIR_W-1:0] DIR_RESERVED = 2'd3;

   // hall patterns, bit 2 is the first sensor
   localparam logic [HALL_W-1:0] HALL_101 = 3'b101;
   localparam logic [HALL_W-1:0] HALL_100 = 3'b100;
   localparam logic [HALL_W-1:0] HALL_110 = 3'b110;
   localparam logic [HALL_W-1:0] HALL_010 = 3'b010;
   localparam logic [HALL_W-1:0] HALL_011 = 3'b011;
   localparam logic [HALL_W-1:0] HALL_001 = 3'b001;
   // sensor faults: all low or all high
   localparam logic [HALL_W-1:0] HALL_000 = 3'b000;
   localparam logic [HALL_W-1:0] HALL_111 = 3'b111;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_STEP      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DUTY       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DUTY       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DANGER_CURRENT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_CENTER     = 3'd4;

   // register reset values
   localparam logic [STEP_W-1:0] DUTY_STEP_RST      = 16'd16;
   localparam logic [DUTY_W-1:0] MIN_DUTY_RST       = 19'd0;
   localparam logic [DUTY_W-1:0] MAX_DUTY_RST       = 19'd4080;
   localparam logic [CUR_W-1:0]  DANGER_CURRENT_RST = 12'd4095;
   localparam logic [CTR_W-1:0]  PWM_CENTER_RST     = 15'd255;

   typedef struct packed {
      logic [DIR_W-1:0]  requested_direction;
      logic [SPD_W-1:0]  target_speed;
      logic [SPD_W-1:0]  measured_speed;
      logic [CUR_W-1:0]  phase_current;
      logic              current_fault;
      logic [HALL_W-1:0] hall_state;
   } req_word_type;

   typedef struct packed {
      logic [CMP_W-1:0] phase_a_compare;
      logic [CMP_W-1:0] phase_b_compare;
      logic [CMP_W-1:0] phase_c_compare;
      logic [DIR_W-1:0] applied_direction;
      logic [LVL_W-1:0] duty_level;
   } rsp_word_type;

   // clip a drive value at zero; the sum of two 15-bit values never exceeds 16 bits
   function automatic logic [CMP_W-1:0] sat_cmp(input logic signed [DRV_W-1:0] v);
      logic [CMP_W-1:0] r;
      r = v[DRV_W-1] ? '0 : v[CMP_W-1:0];
      return r;
   endfunction

endpackage

>>> hdl/bldc_six_step_duty_ramp_unit.sv
// ----------------------------------------------------------------------------
// BLDC six-step duty ramp unit
// Ramped duty control and six-step phase compare generation, one word per
// control tick.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one control tick word (direction request, target
//   and measured speed, current sample, fault flag, hall state). The rsp
//   channel returns one word per req word: three phase compare values, the
//   applied direction and the integer duty level. Both use valid/ready.
//   Path: a req word goes into an input register, then through the
//   duty/commutation logic into the result register, and shows on rsp from there.
//   Throughput: one word per cycle while rsp_ready is high; duty state is updated
//   as the word moves into the result register, so the next word sees it at once.
//   Reset clears the duty accumulator to zero, sets direction to stop, loads
//   the default register values and drops any words in flight.
//   When rsp_ready is low the result word holds, one more word waits in the
//   input register, then req_ready drops until the result is taken.
//   Users write the csr port only with no words in flight (not enforced):
//   0 duty step, 1 min/2 max duty, 3 danger current, 4 PWM center; rest ignored.
// ----------------------------------------------------------------------------
module bldc_six_step_duty_ramp_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [bsdr_pkg::DIR_W-1:0]      req_requested_direction,
   input  logic [bsdr_pkg::SPD_W-1:0]      req_target_speed,
   input  logic [bsdr_pkg::SPD_W-1:0]      req_measured_speed,
   input  logic [bsdr_pkg::CUR_W-1:0]      req_phase_current,
   input  logic                            req_current_fault,
   input  logic [bsdr_pkg::HALL_W-1:0]     req_hall_state,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bsdr_pkg::CMP_W-1:0]      rsp_phase_a_compare,
   output logic [bsdr_pkg::CMP_W-1:0]      rsp_phase_b_compare,
   output logic [bsdr_pkg::CMP_W-1:0]      rsp_phase_c_compare,
   output logic [bsdr_pkg::DIR_W-1:0]      rsp_applied_direction,
   output logic [bsdr_pkg::LVL_W-1:0]      rsp_duty_level,
   input  logic                            csr_wr_en,
   input  logic [bsdr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bsdr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bsdr_pkg::*;

   // config registers
   logic [STEP_W-1:0] duty_step_ff;
   logic [DUTY_W-1:0] min_duty_ff;
   logic [DUTY_W-1:0] max_duty_ff;
   logic [CUR_W-1:0]  danger_current_ff;
   logic [CTR_W-1:0]  pwm_center_ff;

   // state
   logic [DUTY_W-1:0] duty_acc_ff;
   logic [DUTY_W-1:0] duty_acc_in;
   logic [DIR_W-1:0]  drive_dir_ff;
   logic [DIR_W-1:0]  drive_dir_in;

   // pipeline
   logic         s1_valid_ff;
   req_word_type s1_req_ff;
   logic         rsp_valid_ff;
   rsp_word_type rsp_ff;
   rsp_word_type rsp_in;
   logic         advance;

   // datapath
   logic [DIR_W-1:0]         req_dir;
   logic                     ramp_up;
   logic signed [ACC_W-1:0]  acc_s;
   logic signed [ACC_W-1:0]  step_s;
   logic signed [ACC_W-1:0]  step5_s;
   logic signed [ACC_W-1:0]  lo_s;
   logic signed [ACC_W-1:0]  hi_s;
   logic signed [ACC_W-1:0]  d_ramp;
   logic signed [ACC_W-1:0]  d_cur;
   logic signed [ACC_W-1:0]  d_fault;
   logic [LVL_W-1:0]         lvl;
   logic signed [DRV_W-1:0]  center_s;
   logic signed [DRV_W-1:0]  plus_s;
   logic signed [DRV_W-1:0]  minus_s;
   logic [CMP_W-1:0]         cmp_c;
   logic [CMP_W-1:0]         cmp_up;
   logic [CMP_W-1:0]         cmp_dn;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;

   // ---- config port ----
   always_ff @(posedge clock) begin
      if (reset) begin
         duty_step_ff      <= DUTY_STEP_RST;
         min_duty_ff       <= MIN_DUTY_RST;
         max_duty_ff       <= MAX_DUTY_RST;
         danger_current_ff <= DANGER_CURRENT_RST;
         pwm_center_ff     <= PWM_CENTER_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DUTY_STEP:      duty_step_ff      <= csr_wdata[STEP_W-1:0];
            CSR_MIN_DUTY:       min_duty_ff       <= csr_wdata[DUTY_W-1:0];
            CSR_MAX_DUTY:       max_duty_ff       <= csr_wdata[DUTY_W-1:0];
            CSR_DANGER_CURRENT: danger_current_ff <= csr_wdata[CUR_W-1:0];
            CSR_PWM_CENTER:     pwm_center_ff     <= csr_wdata[CTR_W-1:0];
            default: ;
         endcase
      end
   end

   // ---- control and state ----
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         duty_acc_ff  <= '0;
         drive_dir_ff <= DIR_STOP;
      end else begin
         if (req_ready) s1_valid_ff <= req_valid;
         if (advance) rsp_valid_ff <= s1_valid_ff;
         if (s1_valid_ff && advance) begin
            duty_acc_ff  <= duty_acc_in;
            drive_dir_ff <= drive_dir_in;
         end
      end
   end

   // ---- payload registers ----
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff.requested_direction <= req_requested_direction;
         s1_req_ff.target_speed        <= req_target_speed;
         s1_req_ff.measured_speed      <= req_measured_speed;
         s1_req_ff.phase_current       <= req_phase_current;
         s1_req_ff.current_fault       <= req_current_fault;
         s1_req_ff.hall_state          <= req_hall_state;
      end
      if (s1_valid_ff && advance) rsp_ff <= rsp_in;
   end

   // ---- duty ramp ----
   always_comb begin
      // unused code 3 means stop
      req_dir = (s1_req_ff.requested_direction == DIR_RESERVED) ? DIR_STOP
                                                                : s1_req_ff.requested_direction;
      acc_s   = signed'({{(ACC_W-DUTY_W){1'b0}}, duty_acc_ff});
      step_s  = signed'({{(ACC_W-STEP_W){1'b0}}, duty_step_ff});
      step5_s = (step_s <<< 2) + step_s;
      lo_s    = signed'({{(ACC_W-DUTY_W){1'b0}}, min_duty_ff});
      hi_s    = signed'({{(ACC_W-DUTY_W){1'b0}}, max_duty_ff});

      // a pending reversal always ramps down
      ramp_up = (drive_dir_ff == req_dir) &&
                (s1_req_ff.measured_speed < s1_req_ff.target_speed);
      d_ramp  = ramp_up ? acc_s + step_s : acc_s - step_s;

      // switch test sees the ramped duty, before current handling
      drive_dir_in = drive_dir_ff;
      if (drive_dir_ff != req_dir && d_ramp <= lo_s) drive_dir_in = req_dir;

      d_cur   = (s1_req_ff.phase_current >= danger_current_ff) ? d_ramp - step5_s : d_ramp;
      d_fault = s1_req_ff.current_fault ? lo_s : d_cur;

      // min wins over max
      if (d_fault < lo_s)      duty_acc_in = min_duty_ff;
      else if (d_fault > hi_s) duty_acc_in = max_duty_ff;
      else                     duty_acc_in = d_fault[DUTY_W-1:0];

      lvl = duty_acc_in[DUTY_W-1:FRAC_W];
   end

   // ---- six-step commutation ----
   always_comb begin
      center_s = signed'({{(DRV_W-CTR_W){1'b0}}, pwm_center_ff});
      plus_s   = center_s + signed'({{(DRV_W-LVL_W){1'b0}}, lvl});
      minus_s  = center_s - signed'({{(DRV_W-LVL_W){1'b0}}, lvl});
      cmp_c    = {{(CMP_W-CTR_W){1'b0}}, pwm_center_ff};

      unique case (drive_dir_in)
         DIR_LEFT: begin
            cmp_up = sat_cmp(plus_s);
            cmp_dn = sat_cmp(minus_s);
         end
         DIR_RIGHT: begin
            cmp_up = sat_cmp(minus_s);
            cmp_dn = sat_cmp(plus_s);
         end
         default: begin
            cmp_up = cmp_c;
            cmp_dn = cmp_c;
         end
      endcase

      rsp_in.applied_direction = drive_dir_in;
      rsp_in.duty_level        = lvl;

      unique case (s1_req_ff.hall_state)
         HALL_101: begin
            rsp_in.phase_a_compare = cmp_c;
            rsp_in.phase_b_compare = cmp_dn;
            rsp_in.phase_c_compare = cmp_up;
         end
         HALL_100: begin
            rsp_in.phase_a_compare = cmp_up;
            rsp_in.phase_b_compare = cmp_dn;
            rsp_in.phase_c_compare = cmp_c;
         end
         HALL_110: begin
            rsp_in.phase_a_compare = cmp_up;
            rsp_in.phase_b_compare = cmp_c;
            rsp_in.phase_c_compare = cmp_dn;
         end
         HALL_010: begin
            rsp_in.phase_a_compare = cmp_c;
            rsp_in.phase_b_compare = cmp_up;
            rsp_in.phase_c_compare = cmp_dn;
         end
         HALL_011: begin
            rsp_in.phase_a_compare = cmp_dn;
            rsp_in.phase_b_compare = cmp_up;
            rsp_in.phase_c_compare = cmp_c;
         end
         HALL_001: begin
            rsp_in.phase_a_compare = cmp_dn;
            rsp_in.phase_b_compare = cmp_c;
            rsp_in.phase_c_compare = cmp_up;
         end
         default: begin
            // all sensors low or all high: every phase gets the low value
            rsp_in.phase_a_compare = cmp_dn;
            rsp_in.phase_b_compare = cmp_dn;
            rsp_in.phase_c_compare = cmp_dn;
         end
      endcase
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_phase_a_compare   = rsp_ff.phase_a_compare;
   assign rsp_phase_b_compare   = rsp_ff.phase_b_compare;
   assign rsp_phase_c_compare   = rsp_ff.phase_c_compare;
   assign rsp_applied_direction = rsp_ff.applied_direction;
   assign rsp_duty_level        = rsp_ff.duty_level;

endmodule

>>> hdl/bsdr_checker.sv
// ----------------------------------------------------------------------------
// BLDC six-step duty ramp checker
// Port-level checks on the duty ramp unit, attached by bind.
// ----------------------------------------------------------------------------
`include "bldc_six_step_duty_ramp_unit_defines.svh"

module bsdr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [bsdr_pkg::CMP_W-1:0]  rsp_phase_a_compare,
   input logic [bsdr_pkg::CMP_W-1:0]  rsp_phase_b_compare,
   input logic [bsdr_pkg::CMP_W-1:0]  rsp_phase_c_compare,
   input logic [bsdr_pkg::DIR_W-1:0]  rsp_applied_direction,
   input logic [bsdr_pkg::LVL_W-1:0]  rsp_duty_level
);
   import bsdr_pkg::*;

   logic phases_equal;
   assign phases_equal = (rsp_phase_a_compare == rsp_phase_b_compare) &&
                         (rsp_phase_b_compare == rsp_phase_c_compare);

   `BSDR_ASSERT_NXT(a_reset_flush, clock, 1'b0, reset, !rsp_valid && req_ready, "words survived reset")

   `BSDR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_phase_a_compare) && $stable(rsp_phase_b_compare) && $stable(rsp_phase_c_compare) && $stable(rsp_applied_direction) && $stable(rsp_duty_level), "stalled rsp word changed")

   `BSDR_ASSERT_IMP(a_stop_centered, clock, reset, rsp_valid && rsp_applied_direction == DIR_STOP, phases_equal, "stop word with unequal phases")

   `BSDR_ASSERT_IMP(a_zero_duty_centered, clock, reset, rsp_valid && rsp_duty_level == '0, phases_equal, "zero duty word with unequal phases")

   // no stall on the result side means nothing backs up to the input
   `BSDR_ASSERT_IMP(a_ready_when_drained, clock, reset, !rsp_valid, req_ready, "req stalled with empty result register")

endmodule

bind bldc_six_step_duty_ramp_unit bsdr_checker u_bsdr_checker (.*);
